FILE: hw/rtl/tsra_pkg.sv
// ----------------------------------------------------------------------------
// tsra_pkg
// Shared types and constants of the tagged stack region allocator.
// ----------------------------------------------------------------------------
package tsra_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic {
    REG_POOL_BASE = 1'b0,
    REG_POOL_SIZE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP       = 3'd1,
    CMD_FIND_T    = 3'd2,
    CMD_FIND_TP   = 3'd3,
    CMD_FIND_NEXT = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_ROOM   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PUSH,
    S_POP,
    S_POP_WB,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  part_type;
    logic [7:0]  part_purpose;
    logic [31:0] bytes;
  } entry_t;

endpackage

FILE: hw/rtl/tsra_cmd_if.sv
// ----------------------------------------------------------------------------
// tsra_cmd_if
// Command channel of the allocator: valid/ready plus request payload.
// ----------------------------------------------------------------------------
interface tsra_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [7:0]        part_type;
  logic [7:0]        part_purpose;
  logic [15:0]       unit_size;
  logic [15:0]       unit_count;
  logic signed [5:0] start_after;

  modport source (
    output valid, command, part_type, part_purpose, unit_size, unit_count, start_after,
    input  ready
  );

  modport sink (
    input  valid, command, part_type, part_purpose, unit_size, unit_count, start_after,
    output ready
  );
endinterface

FILE: hw/rtl/tsra_rsp_if.sv
// ----------------------------------------------------------------------------
// tsra_rsp_if
// Response channel of the allocator: valid/ready plus result payload.
// ----------------------------------------------------------------------------
interface tsra_rsp_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [5:0] found_index;
  logic [31:0]       part_address;
  logic [31:0]       free_bytes;
  logic [5:0]        part_total;

  modport source (
    output valid, status, found_index, part_address, free_bytes, part_total,
    input  ready
  );

  modport sink (
    input  valid, status, found_index, part_address, free_bytes, part_total,
    output ready
  );
endinterface

FILE: hw/rtl/tagged_stack_region_allocator.sv
// ----------------------------------------------------------------------------
// tagged_stack_region_allocator
// LIFO arena allocator with a descriptor table, sequenced around one table
// read port, one 16x16 multiplier and 32-bit adders and comparators.
// ----------------------------------------------------------------------------
// channel   dir   handshake              payload
// in_i      in    valid/ready            command, tags, unit size/count, start
// out_o     out   valid/ready            status, index, address, free, total
// apb       in    psel/penable/pwrite    pool_base (0x0), pool_size (0x4)
//
// Push: accept, multiply, commit, result. Pop: accept, read, write-back,
// result (no write-back when empty). Unknown command: accept, result.
// Find: accept, scan of up to MAX_PARTS descriptors, result, with one table
// read per cycle through the registered read port.
// A new command is taken while the previous result waits on out_o; the
// sequencer stalls in its result state until the output register frees.
// Reset empties the table and loads base/size of 0; a register write restarts.
// ----------------------------------------------------------------------------
module tagged_stack_region_allocator
  import tsra_pkg::*;
#(
  parameter int unsigned MAX_PARTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tsra_cmd_if.sink            in_i,
  tsra_rsp_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned IdxW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_PARTS + 1);
  localparam int unsigned PtrW = (CntW > 6) ? CntW : 6;

  state_e state_q, state_d;

  logic [31:0]     pool_base_q, pool_size_q;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     nfa_q, nfa_d;
  logic [31:0]     rem_q, rem_d;

  logic [2:0]        cmd_q, cmd_d;
  logic [7:0]        type_q, type_d;
  logic [7:0]        purpose_q, purpose_d;
  logic [15:0]       usize_q, usize_d;
  logic [15:0]       ucount_q, ucount_d;
  logic signed [5:0] sa_q, sa_d;
  logic [31:0]       bytes_q, bytes_d;

  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [PtrW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_vld_q, rd_vld_d;

  status_e     res_status_q, res_status_d;
  logic [5:0]  res_idx_q, res_idx_d;
  logic [31:0] res_addr_q, res_addr_d;

  logic        out_valid_q, out_valid_d;
  status_e     out_status_q;
  logic [5:0]  out_idx_q;
  logic [31:0] out_addr_q, out_free_q;
  logic [5:0]  out_total_q;

  entry_t          mem [MAX_PARTS];
  entry_t          mem_rdata_q;
  entry_t          mem_wdata;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [IdxW-1:0] rd_addr;

  logic            cfg_we;
  logic            accept;
  logic            out_free;
  logic            is_full;
  logic            in_range;
  logic            hit;
  logic [CntW-1:0] cnt_m1;
  logic [PtrW-1:0] cnt_ext;
  logic [PtrW-1:0] first_ptr;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_POOL_SIZE) ? pool_size_q : pool_base_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign is_full  = (count_q == CntW'(MAX_PARTS));
  assign cnt_m1   = count_q - 1'b1;
  assign cnt_ext  = PtrW'(count_q);
  assign in_range = (ptr_q < cnt_ext);
  assign hit      = rd_vld_q && (mem_rdata_q.part_type == type_q) &&
                    ((cmd_q != CMD_FIND_TP) || (mem_rdata_q.part_purpose == purpose_q));
  assign first_ptr = (in_i.command == CMD_FIND_NEXT && !in_i.start_after[5]) ?
                     PtrW'(in_i.start_after[4:0]) + 1'b1 : '0;

  assign rd_addr   = (state_q == S_POP) ? cnt_m1[IdxW-1:0] : ptr_q[IdxW-1:0];
  assign mem_waddr = count_q[IdxW-1:0];
  assign mem_wdata = '{address: nfa_q, part_type: type_q, part_purpose: purpose_q,
                       bytes: bytes_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_i.command)
            CMD_PUSH:                               state_d = S_MUL;
            CMD_POP:                                state_d = S_POP;
            CMD_FIND_T, CMD_FIND_TP, CMD_FIND_NEXT: state_d = S_SCAN;
            default:                                state_d = S_DONE;
          endcase
        end
      end
      S_MUL:    state_d = S_PUSH;
      S_PUSH:   state_d = S_DONE;
      S_POP:    state_d = (count_q == '0) ? S_DONE : S_POP_WB;
      S_POP_WB: state_d = S_DONE;
      S_SCAN:   state_d = (hit || !in_range) ? S_DONE : S_SCAN;
      S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    count_d      = count_q;
    nfa_d        = nfa_q;
    rem_d        = rem_q;
    cmd_d        = cmd_q;
    type_d       = type_q;
    purpose_d    = purpose_q;
    usize_d      = usize_q;
    ucount_d     = ucount_q;
    sa_d         = sa_q;
    bytes_d      = bytes_q;
    ptr_d        = ptr_q;
    rd_idx_d     = rd_idx_q;
    rd_vld_d     = 1'b0;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    mem_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d        = in_i.command;
          type_d       = in_i.part_type;
          purpose_d    = in_i.part_purpose;
          usize_d      = in_i.unit_size;
          ucount_d     = in_i.unit_count;
          sa_d         = in_i.start_after;
          ptr_d        = first_ptr;
          res_status_d = ST_NOT_FOUND;
          res_idx_d    = '1;
          res_addr_d   = '0;
        end
      end
      S_MUL: begin
        bytes_d = usize_q * ucount_q;
      end
      S_PUSH: begin
        if (is_full) begin
          res_status_d = ST_FULL;
        end else if (bytes_q > rem_q) begin
          res_status_d = ST_NO_ROOM;
        end else begin
          mem_we       = 1'b1;
          count_d      = count_q + 1'b1;
          rem_d        = rem_q - bytes_q;
          nfa_d        = nfa_q + bytes_q;
          res_status_d = ST_OK;
          res_idx_d    = cnt_ext[5:0];
          res_addr_d   = nfa_q;
        end
      end
      S_POP: begin
        if (count_q == '0) begin
          res_status_d = ST_EMPTY;
        end
      end
      S_POP_WB: begin
        count_d      = cnt_m1;
        rem_d        = rem_q + mem_rdata_q.bytes;
        nfa_d        = mem_rdata_q.address;
        res_status_d = ST_OK;
        res_idx_d    = 6'(cnt_m1);
        res_addr_d   = mem_rdata_q.address;
      end
      S_SCAN: begin
        if (hit) begin
          res_status_d = ST_OK;
          res_idx_d    = rd_idx_q[5:0];
          res_addr_d   = mem_rdata_q.address;
        end else if (in_range) begin
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_q;
          ptr_d    = ptr_q + 1'b1;
        end else begin
          res_status_d = ST_NOT_FOUND;
          res_addr_d   = '0;
          res_idx_d    = (cmd_q == CMD_FIND_NEXT) ? sa_q : '1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase

    if (cfg_we) begin
      count_d = '0;
      nfa_d   = (paddr[2] == REG_POOL_BASE) ? pwdata : pool_base_q;
      rem_d   = (paddr[2] == REG_POOL_SIZE) ? pwdata : pool_size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_base_q <= '0;
      pool_size_q <= '0;
      count_q     <= '0;
      nfa_q       <= '0;
      rem_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      nfa_q       <= nfa_d;
      rem_q       <= rem_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we && paddr[2] == REG_POOL_BASE) begin
        pool_base_q <= pwdata;
      end
      if (cfg_we && paddr[2] == REG_POOL_SIZE) begin
        pool_size_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    type_q       <= type_d;
    purpose_q    <= purpose_d;
    usize_q      <= usize_d;
    ucount_q     <= ucount_d;
    sa_q         <= sa_d;
    bytes_q      <= bytes_d;
    ptr_q        <= ptr_d;
    rd_idx_q     <= rd_idx_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_addr_q   <= res_addr_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_addr_q   <= res_addr_q;
      out_free_q   <= rem_q;
      out_total_q  <= cnt_ext[5:0];
    end
  end

  // descriptor table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[rd_addr];
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.found_index  = out_idx_q;
  assign out_o.part_address = out_addr_q;
  assign out_o.free_bytes   = out_free_q;
  assign out_o.part_total   = out_total_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_PARTS))
    else $error("part count above table depth");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !in_range) |=> (state_q != S_SCAN))
    else $error("scan continued past last descriptor");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> (count_q == '0))
    else $error("register write did not empty the table");
`endif

endmodule
